### sv/rhps_pkg.sv
// Types and constants for the reciprocal hit pair scorer.
package rhps_pkg;

    localparam int unsigned POS_W = 31;
    localparam int unsigned ID_W = 17;
    localparam int unsigned COV_W = 14;
    localparam int unsigned SCORE_W = 30;
    localparam int unsigned MUT_W = 60;
    localparam int unsigned ALEN_W = 32;
    localparam logic [COV_W-1:0] COVER_MAX = 14'd10000;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 30'h3FFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAIR,
        S_SUM,
        S_UNION,
        S_DLOAD,
        S_DIV,
        S_MUL1,
        S_MUL2
    } t_state;

    typedef enum logic [1:0] {
        DSEL_PID,
        DSEL_FWD,
        DSEL_REV
    } t_dsel;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_range;

    typedef struct packed {
        t_range           a;
        t_range           b;
        logic [ID_W-1:0]  idn;
        logic             dir;
        logic [POS_W-1:0] len_a;
        logic [POS_W-1:0] len_b;
    } t_entry;

    function automatic logic range_within(t_range inner, t_range outer);
        return (outer.lo <= inner.lo) && (inner.hi <= outer.hi);
    endfunction

    function automatic logic [ALEN_W-1:0] range_len(t_range r);
        return {1'b0, r.hi} - {1'b0, r.lo} + ALEN_W'(1);
    endfunction

endpackage

### sv/reciprocal_hit_pair_scorer_unit.sv
// Reciprocal hit pair scorer: hit store, removal scan, union scan, divider, scores.
//
// Usage: present one hit on the i_ field ports with start high; it is taken
// at a rising edge where start is high and busy is low. Hits of one group go
// in one per cycle while busy is low. The hit with i_last high closes the
// group; busy then stays high while the group is scored.
// Scoring walks the hit memory: a pairwise removal scan, a sum scan, a union
// scan per direction that walks the memory again for each range it merges,
// three restoring divisions and the multiplies.
// The n*n pairwise scan over the two read ports of the memory dominates.
// A result, if both directions have survivors, shows on the o_ result ports
// for one cycle with o_valid high; the receiver cannot stall, so it must
// take it then. A group without survivors in both directions gives no
// result. Hits beyond MAX_HITS are dropped and flagged on o_overflow with the result.
// Reset clears the hit count and the overflow flag; memory contents are
// not cleared and are only read below the count.
module reciprocal_hit_pair_scorer_unit
    import rhps_pkg::*;
#(
    parameter int unsigned MAX_HITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [POS_W-1:0]     i_a_start,
    input  logic [POS_W-1:0]     i_a_end,
    input  logic [POS_W-1:0]     i_b_start,
    input  logic [POS_W-1:0]     i_b_end,
    input  logic [ID_W-1:0]      i_identity,
    input  logic                 i_direction,
    input  logic [POS_W-1:0]     i_length_a,
    input  logic [POS_W-1:0]     i_length_b,
    input  logic                 i_last,
    output logic                 o_valid,
    output logic [ID_W-1:0]      o_pair_identity,
    output logic [COV_W-1:0]     o_cover_forward,
    output logic                 o_cover_forward_ok,
    output logic [COV_W-1:0]     o_cover_reverse,
    output logic                 o_cover_reverse_ok,
    output logic [SCORE_W-1:0]   o_score_forward,
    output logic [SCORE_W-1:0]   o_score_reverse,
    output logic [MUT_W-1:0]     o_score_mutual,
    output logic                 o_overflow
);

    localparam int unsigned IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int unsigned CW = $clog2(MAX_HITS + 1);
    localparam int unsigned ALW = ALEN_W + IW;
    localparam int unsigned PW = ALEN_W + ID_W;
    localparam int unsigned WSW = PW + IW;
    localparam int unsigned DNW = WSW + 2;
    localparam int unsigned DDW = ALW + 1;
    localparam int unsigned DCW = $clog2(DNW + 1);

    t_entry r_mem [MAX_HITS];
    t_entry r_rda, r_rdb, w_entry;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_ovf, n_ovf;
    logic [MAX_HITS-1:0] r_removed, n_removed;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_pi, r_pj, last_idx;
    logic r_iss, n_iss, r_pv;
    logic r_first, n_first;
    logic [POS_W-1:0] r_lena, n_lena, r_lenb, n_lenb;
    logic r_has0, n_has0, r_has1, n_has1;
    logic [ALW-1:0] r_aln, n_aln;
    logic [WSW-1:0] r_wsum, n_wsum;
    logic [PW-1:0] r_prod, n_prod;
    logic r_mv, n_mv;
    logic r_dir, n_dir;
    t_range r_cur, n_cur, r_best, n_best, key;
    logic r_found, n_found, r_started, n_started;
    logic [POS_W-1:0] r_cs, n_cs, r_ce, n_ce;
    logic [ALEN_W-1:0] r_tot, n_tot, r_uf, n_uf, r_ur, n_ur;
    t_dsel r_dsel, n_dsel;
    logic [DNW-1:0] r_dq, n_dq;
    logic [DDW-1:0] r_drem, n_drem, r_dd, n_dd;
    logic [DCW-1:0] r_dcnt, n_dcnt;
    logic [ID_W-1:0] r_pid, n_pid;
    logic [COV_W-1:0] r_cf, n_cf, r_cr, n_cr;
    logic [SCORE_W-1:0] r_sf, n_sf, r_sr, n_sr;
    logic [MUT_W-1:0] r_mut, n_mut;
    logic r_valid, n_valid, r_okf, n_okf, r_okr, n_okr, r_oovf, n_oovf;

    logic accept, full, hit, same;
    logic [DDW:0] rem_sh;
    logic [DNW-1:0] u_num;
    logic [ALEN_W-1:0] u_sel;
    logic [POS_W-1:0] len_sel;
    logic [SCORE_W:0] p_f, p_r;

    assign accept = start && !busy;
    assign full = (r_cnt == CW'(MAX_HITS));
    assign last_idx = IW'(r_cnt - CW'(1));
    assign busy = (r_state != S_IDLE);

    always_comb begin
        w_entry.a.lo = (i_a_start > i_a_end) ? i_a_end : i_a_start;
        w_entry.a.hi = (i_a_start > i_a_end) ? i_a_start : i_a_end;
        w_entry.b.lo = (i_b_start > i_b_end) ? i_b_end : i_b_start;
        w_entry.b.hi = (i_b_start > i_b_end) ? i_b_start : i_b_end;
        w_entry.idn = i_identity;
        w_entry.dir = i_direction;
        w_entry.len_a = i_length_a;
        w_entry.len_b = i_length_b;
    end

    always_ff @(posedge i_clk) begin
        if (accept && !full) begin
            r_mem[r_cnt[IW-1:0]] <= w_entry;
        end
        r_rda <= r_mem[r_i];
        r_rdb <= r_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_iss <= 1'b0;
            r_pv <= 1'b0;
            r_mv <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
            r_iss <= n_iss;
            r_pv <= r_iss;
            r_mv <= n_mv;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_removed <= n_removed;
        r_i <= n_i;
        r_j <= n_j;
        r_pi <= r_i;
        r_pj <= r_j;
        r_first <= n_first;
        r_lena <= n_lena;
        r_lenb <= n_lenb;
        r_has0 <= n_has0;
        r_has1 <= n_has1;
        r_aln <= n_aln;
        r_wsum <= n_wsum;
        r_prod <= n_prod;
        r_dir <= n_dir;
        r_cur <= n_cur;
        r_best <= n_best;
        r_found <= n_found;
        r_started <= n_started;
        r_cs <= n_cs;
        r_ce <= n_ce;
        r_tot <= n_tot;
        r_uf <= n_uf;
        r_ur <= n_ur;
        r_dsel <= n_dsel;
        r_dq <= n_dq;
        r_drem <= n_drem;
        r_dd <= n_dd;
        r_dcnt <= n_dcnt;
        r_pid <= n_pid;
        r_cf <= n_cf;
        r_cr <= n_cr;
        r_sf <= n_sf;
        r_sr <= n_sr;
        r_mut <= n_mut;
        r_okf <= n_okf;
        r_okr <= n_okr;
        r_oovf <= n_oovf;
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_removed = r_removed;
        n_i = r_i;
        n_j = r_j;
        n_iss = r_iss;
        n_first = r_first;
        n_lena = r_lena;
        n_lenb = r_lenb;
        n_has0 = r_has0;
        n_has1 = r_has1;
        n_aln = r_aln;
        n_wsum = r_wsum;
        n_prod = r_prod;
        n_mv = 1'b0;
        n_dir = r_dir;
        n_cur = r_cur;
        n_best = r_best;
        n_found = r_found;
        n_started = r_started;
        n_cs = r_cs;
        n_ce = r_ce;
        n_tot = r_tot;
        n_uf = r_uf;
        n_ur = r_ur;
        n_dsel = r_dsel;
        n_dq = r_dq;
        n_drem = r_drem;
        n_dd = r_dd;
        n_dcnt = r_dcnt;
        n_pid = r_pid;
        n_cf = r_cf;
        n_cr = r_cr;
        n_sf = r_sf;
        n_sr = r_sr;
        n_mut = r_mut;
        n_valid = 1'b0;
        n_okf = r_okf;
        n_okr = r_okr;
        n_oovf = r_oovf;
        same = (r_rda.a == r_rdb.a) && (r_rda.b == r_rdb.b);
        hit = 1'b0;
        key = r_dir ? r_rdb.b : r_rdb.a;
        rem_sh = {r_drem, r_dq[DNW-1]};
        u_sel = (r_dsel == DSEL_FWD) ? r_uf : r_ur;
        len_sel = (r_dsel == DSEL_FWD) ? r_lena : r_lenb;
        u_num = (DNW'(u_sel) << 7) + (DNW'(u_sel) << 6) + (DNW'(u_sel) << 3)
              + DNW'(len_sel);
        p_f = (SCORE_W+1)'(r_pid * r_cf);
        p_r = (SCORE_W+1)'(r_pid * r_cr);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (i_last) begin
                        n_state = S_PAIR;
                        n_removed = '0;
                        n_i = '0;
                        n_j = '0;
                        n_iss = 1'b1;
                    end
                end
            end
            S_PAIR: begin
                if (r_iss) begin
                    if (r_j == last_idx) begin
                        n_j = '0;
                        if (r_i == last_idx) begin
                            n_iss = 1'b0;
                        end else begin
                            n_i = r_i + IW'(1);
                        end
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end
                if (r_pv && (r_pi != r_pj) && (r_rda.dir == r_rdb.dir)) begin
                    hit = (same && (r_pj < r_pi)) ||
                          (!same && (range_within(r_rda.a, r_rdb.a) ||
                                     range_within(r_rda.b, r_rdb.b)));
                    if (hit) begin
                        n_removed[r_pi] = 1'b1;
                    end
                end
                if (!r_iss && !r_pv) begin
                    n_state = S_SUM;
                    n_j = '0;
                    n_iss = 1'b1;
                    n_first = 1'b0;
                    n_has0 = 1'b0;
                    n_has1 = 1'b0;
                    n_aln = '0;
                    n_wsum = '0;
                end
            end
            S_SUM: begin
                if (r_iss) begin
                    if (r_j == last_idx) begin
                        n_iss = 1'b0;
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end
                if (r_mv) begin
                    n_wsum = r_wsum + WSW'(r_prod);
                end
                if (r_pv && !r_removed[r_pj]) begin
                    if (!r_first) begin
                        n_first = 1'b1;
                        n_lena = r_rdb.len_a;
                        n_lenb = r_rdb.len_b;
                    end
                    if (r_rdb.dir) begin
                        n_has1 = 1'b1;
                    end else begin
                        n_has0 = 1'b1;
                    end
                    n_aln = r_aln + ALW'(range_len(r_rdb.a));
                    n_prod = range_len(r_rdb.a) * r_rdb.idn;
                    n_mv = 1'b1;
                end
                if (!r_iss && !r_pv && !r_mv) begin
                    if (r_has0 && r_has1) begin
                        n_state = S_UNION;
                        n_dir = 1'b0;
                        n_started = 1'b0;
                        n_found = 1'b0;
                        n_tot = '0;
                        n_j = '0;
                        n_iss = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                        n_cnt = '0;
                        n_ovf = 1'b0;
                    end
                end
            end
            S_UNION: begin
                if (r_iss) begin
                    if (r_j == last_idx) begin
                        n_iss = 1'b0;
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end
                if (r_pv && !r_removed[r_pj] && (r_rdb.dir == r_dir) &&
                    (!r_started || (key > r_cur)) && (!r_found || (key < r_best))) begin
                    n_found = 1'b1;
                    n_best = key;
                end
                if (!r_iss && !r_pv) begin
                    n_j = '0;
                    n_iss = 1'b1;
                    n_found = 1'b0;
                    if (r_found) begin
                        n_cur = r_best;
                        n_started = 1'b1;
                        if (!r_started) begin
                            n_cs = r_best.lo;
                            n_ce = r_best.hi;
                        end else if (r_best.lo <= r_ce) begin
                            if (r_best.hi > r_ce) begin
                                n_ce = r_best.hi;
                            end
                        end else begin
                            n_tot = r_tot + {1'b0, r_ce} - {1'b0, r_cs} + ALEN_W'(1);
                            n_cs = r_best.lo;
                            n_ce = r_best.hi;
                        end
                    end else begin
                        n_started = 1'b0;
                        n_tot = '0;
                        if (r_dir) begin
                            n_ur = r_tot + {1'b0, r_ce} - {1'b0, r_cs} + ALEN_W'(1);
                            n_iss = 1'b0;
                            n_state = S_DLOAD;
                            n_dsel = DSEL_PID;
                        end else begin
                            n_uf = r_tot + {1'b0, r_ce} - {1'b0, r_cs} + ALEN_W'(1);
                            n_dir = 1'b1;
                        end
                    end
                end
            end
            S_DLOAD: begin
                n_drem = '0;
                n_dcnt = DCW'(DNW);
                n_state = S_DIV;
                if (r_dsel == DSEL_PID) begin
                    n_dq = DNW'({r_wsum, 1'b0}) + DNW'(r_aln);
                    n_dd = {r_aln, 1'b0};
                end else begin
                    n_dq = u_num;
                    n_dd = DDW'({len_sel, 1'b0});
                end
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    n_dcnt = r_dcnt - DCW'(1);
                    if (rem_sh >= {1'b0, r_dd}) begin
                        n_drem = DDW'(rem_sh - {1'b0, r_dd});
                        n_dq = {r_dq[DNW-2:0], 1'b1};
                    end else begin
                        n_drem = rem_sh[DDW-1:0];
                        n_dq = {r_dq[DNW-2:0], 1'b0};
                    end
                end else begin
                    case (r_dsel)
                        DSEL_PID: begin
                            n_pid = r_dq[ID_W-1:0];
                            n_dsel = DSEL_FWD;
                            n_state = S_DLOAD;
                        end
                        DSEL_FWD: begin
                            n_cf = (r_lena == '0) ? '0 :
                                   (r_dq > DNW'(COVER_MAX)) ? COVER_MAX : r_dq[COV_W-1:0];
                            n_dsel = DSEL_REV;
                            n_state = S_DLOAD;
                        end
                        default: begin
                            n_cr = (r_lenb == '0) ? '0 :
                                   (r_dq > DNW'(COVER_MAX)) ? COVER_MAX : r_dq[COV_W-1:0];
                            n_state = S_MUL1;
                        end
                    endcase
                end
            end
            S_MUL1: begin
                n_sf = (p_f > {1'b0, SCORE_MAX}) ? SCORE_MAX : p_f[SCORE_W-1:0];
                n_sr = (p_r > {1'b0, SCORE_MAX}) ? SCORE_MAX : p_r[SCORE_W-1:0];
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_okf = (r_lena != '0);
                n_okr = (r_lenb != '0);
                n_mut = ((r_lena != '0) && (r_lenb != '0)) ? r_sf * r_sr : '0;
                n_oovf = r_ovf;
                n_valid = 1'b1;
                n_cnt = '0;
                n_ovf = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_pair_identity = r_pid;
    assign o_cover_forward = r_cf;
    assign o_cover_forward_ok = r_okf;
    assign o_cover_reverse = r_cr;
    assign o_cover_reverse_ok = r_okr;
    assign o_score_forward = r_sf;
    assign o_score_reverse = r_sr;
    assign o_score_mutual = r_mut;
    assign o_overflow = r_oovf;

    a_valid_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_MUL2))
        else $error("result strobe without finished scoring");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_HITS))
        else $error("hit count above capacity");

    a_cover_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (o_cover_forward <= COVER_MAX) && (o_cover_reverse <= COVER_MAX))
        else $error("coverage above saturation");

    a_cover_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_cover_forward_ok) |-> (o_score_forward == '0) &&
                                            (o_score_mutual == '0))
        else $error("score set with undefined forward coverage");

endmodule
